### hdl/jcq_pkg.sv
package jcq_pkg;

  localparam int unsigned HEADROOM_DEF   = 3;
  localparam int unsigned BLOCK_AREA_DEF = 64;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_QUANT  = 2'd1;
  localparam logic [1:0] CMD_DEQ    = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Bits of the dividend 2^(15+L), L the bit length of an 8-bit step
  localparam int unsigned DIV_BITS = 24;
  localparam int unsigned CNT_W    = 5;

  typedef struct packed {
    logic [7:0]  step;
    logic [15:0] recip;
    logic [15:0] corr;
    logic [4:0]  shift;
  } qent_t;

  localparam int unsigned QENT_W = $bits(qent_t);

endpackage

### hdl/jpeg_coefficient_quantizer_core.sv
// Channel  Dir  Ports                        Beat contents
// in_      in   tvalid tready tdata tuser    tuser: cmd; tdata: index, coeff, step_value
// out_     out  tvalid tready tdata          tdata: value
//
// Quantize and dequantize beats enter one per cycle while the divider is idle and out_ flows;
// each result passes table read, add, multiply and shift/sign, held in the output register
// under back-pressure. A valid table load holds in_tready low while the bit-serial
// divider works out the reciprocal; loads with zero step or out-of-range index pass at once.
// Synchronous active-low reset clears the valid bits and the divider; the table is not cleared.
// An out_ stall freezes a full stage if all later ones are full; nothing is lost or repeated.
module jpeg_coefficient_quantizer_core #(
  parameter int unsigned HEADROOM   = jcq_pkg::HEADROOM_DEF,
  parameter int unsigned BLOCK_AREA = jcq_pkg::BLOCK_AREA_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // index[5:0], coeff[21:6], step_value[29:22], zero pad
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // value[15:0]
);

  localparam int unsigned AW = (BLOCK_AREA > 1) ? $clog2(BLOCK_AREA) : 1;

  logic [5:0]  in_index;
  logic [15:0] in_coeff;
  logic [7:0]  in_step;
  logic        in_fire, in_inside, is_res, is_load;
  logic [AW-1:0] in_addr;

  assign in_index  = in_tdata[5:0];
  assign in_coeff  = in_tdata[21:6];
  assign in_step   = in_tdata[29:22];
  assign in_fire   = in_tvalid && in_tready;
  assign in_inside = {3'b0, in_index} < 9'(BLOCK_AREA);
  assign in_addr   = AW'({3'b0, in_index});
  assign is_res    = (in_tuser == jcq_pkg::CMD_QUANT) || (in_tuser == jcq_pkg::CMD_DEQ);
  assign is_load   = (in_tuser == jcq_pkg::CMD_LOAD) && in_inside && (in_step != 8'd0);

  // ---------------- divider for table loads ----------------
  logic                          dv_busy_r, dv_fin_r;
  logic [jcq_pkg::CNT_W-1:0]     dv_cnt_r;
  logic [8:0]                    dv_rem_r;
  logic [16:0]                   dv_quo_r;
  logic [7:0]                    dv_step_r;
  logic [AW-1:0]                 dv_addr_r;
  logic [3:0]                    dv_len;
  logic [8:0]                    dv_try;
  logic                          dv_ge;

  always_comb begin
    dv_len = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (dv_step_r[i]) dv_len = 4'(i + 1);
    end
  end

  assign dv_try = {dv_rem_r[7:0], (dv_cnt_r == 5'(5'd15 + 5'(dv_len)))};
  assign dv_ge  = dv_try >= {1'b0, dv_step_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_busy_r <= 1'b0;
      dv_fin_r  <= 1'b0;
    end else if (!dv_busy_r) begin
      if (in_fire && is_load) begin
        dv_busy_r <= 1'b1;
        dv_fin_r  <= 1'b0;
      end
    end else if (dv_fin_r) begin
      dv_busy_r <= 1'b0;
      dv_fin_r  <= 1'b0;
    end else if (dv_cnt_r == '0) begin
      dv_fin_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!dv_busy_r) begin
      dv_step_r <= in_step;
      dv_addr_r <= in_addr;
      dv_cnt_r  <= jcq_pkg::CNT_W'(jcq_pkg::DIV_BITS - 1);
      dv_rem_r  <= '0;
      dv_quo_r  <= '0;
    end else if (!dv_fin_r) begin
      dv_rem_r <= dv_ge ? dv_try - {1'b0, dv_step_r} : dv_try;
      dv_quo_r <= {dv_quo_r[15:0], dv_ge};
      dv_cnt_r <= dv_cnt_r - 1'b1;
    end
  end

  jcq_pkg::qent_t wr_ent;
  logic [15:0]    dv_d;
  logic [16:0]    dv_fq;
  logic [4:0]     dv_r;

  always_comb begin
    dv_d  = 16'(dv_step_r) << HEADROOM;
    dv_r  = 5'(5'd15 + 5'(HEADROOM) + 5'(dv_len));
    dv_fq = dv_quo_r;
    wr_ent.step = dv_step_r;
    wr_ent.corr = dv_d >> 1;
    if (HEADROOM == 0 && dv_step_r == 8'd1) begin
      dv_fq       = 17'd1;
      dv_r        = 5'd0;
      wr_ent.corr = 16'd0;
    end else if (dv_rem_r == 9'd0) begin
      dv_fq = dv_quo_r >> 1;
      dv_r  = dv_r - 5'd1;
    end else if ({dv_rem_r[7:0], 1'b0} <= {1'b0, dv_step_r}) begin
      wr_ent.corr = (dv_d >> 1) + 16'd1;
    end else begin
      dv_fq = dv_quo_r + 17'd1;
    end
    wr_ent.recip = dv_fq[15:0];
    wr_ent.shift = dv_r;
  end

  // ---------------- pipeline ----------------
  logic rdy1, rdy2, rdy3, rdy4;
  logic v1_r, v2_r, v3_r;
  logic q1_r, q2_r, q3_r;
  logic in1_r, in2_r, in3_r;
  logic neg2_r, neg3_r;
  logic [15:0] coeff1_r, coeff2_r;
  logic [16:0] sum2_r;
  logic [15:0] recip2_r;
  logic [4:0]  shift2_r, shift3_r;
  logic [7:0]  step2_r;
  logic [32:0] prod3_r;
  logic [15:0] deq3_r;
  logic [jcq_pkg::QENT_W-1:0] rd_raw;
  jcq_pkg::qent_t rd_ent;

  assign rdy4 = !out_tvalid || out_tready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_tready = rdy1 && !dv_busy_r;
  assign rd_ent = jcq_pkg::qent_t'(rd_raw);

  jcq_ram #(
    .WIDTH (jcq_pkg::QENT_W),
    .DEPTH (BLOCK_AREA)
  ) u_tab (
    .clk     (clk),
    .wr_en   (dv_busy_r && dv_fin_r),
    .wr_addr (dv_addr_r),
    .wr_data (wr_ent),
    .rd_en   (in_fire),
    .rd_addr (in_addr),
    .rd_data (rd_raw)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_fire && is_res;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) out_tvalid <= v3_r;
    end
  end

  logic        neg1;
  logic [16:0] mag1;
  logic [15:0] lo4;
  logic [32:0] sh4;

  assign neg1 = coeff1_r[15];
  assign mag1 = neg1 ? 17'h10000 - {1'b0, coeff1_r} : {1'b0, coeff1_r};
  assign sh4  = prod3_r >> shift3_r;
  assign lo4  = sh4[15:0];

  always_ff @(posedge clk) begin
    if (rdy1) begin
      q1_r     <= (in_tuser == jcq_pkg::CMD_QUANT);
      in1_r    <= in_inside;
      coeff1_r <= in_coeff;
    end
    if (rdy2) begin
      q2_r     <= q1_r;
      in2_r    <= in1_r;
      neg2_r   <= neg1;
      sum2_r   <= mag1 + {1'b0, rd_ent.corr};
      recip2_r <= rd_ent.recip;
      shift2_r <= rd_ent.shift;
      coeff2_r <= coeff1_r;
      step2_r  <= rd_ent.step;
    end
    if (rdy3) begin
      q3_r     <= q2_r;
      in3_r    <= in2_r;
      neg3_r   <= neg2_r;
      shift3_r <= shift2_r;
      prod3_r  <= 33'(sum2_r) * 33'(recip2_r);
      deq3_r   <= 16'(coeff2_r * 16'(step2_r));
    end
    if (rdy4) begin
      // output zero for an index beyond the table
      if (!in3_r) begin
        out_tdata <= 16'd0;
      end else if (q3_r) begin
        out_tdata <= neg3_r ? 16'd0 - lo4 : lo4;
      end else begin
        out_tdata <= deq3_r;
      end
    end
  end

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    dv_busy_r |-> !in_tready) else $error("input taken while divider busy");

  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && is_load |=> dv_busy_r && !dv_fin_r) else $error("load did not start divider");

  a_fin_ends: assert property (@(posedge clk) disable iff (!rst_n)
    dv_busy_r && dv_fin_r |=> !dv_busy_r) else $error("divider did not finish");

endmodule

### hdl/jcq_ram.sv
module jcq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
